>>> sv/llcpe_pkg.sv
// Package for the cache policy engine: widths, command and mode codes, word types.
// Used by lru_lfu_cache_policy_engine. No other dependencies.
package llcpe_pkg;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned IdxBits   = 4;
  localparam int unsigned OccBits   = 5;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned CountBits = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits   = 32;

  localparam logic [2:0] CmdGet    = 3'd0;
  localparam logic [2:0] CmdSet    = 3'd1;
  localparam logic [2:0] CmdRemove = 3'd2;
  localparam logic [2:0] CmdClear  = 3'd3;
  localparam logic [2:0] CmdTick   = 3'd4;

  localparam logic [1:0] ModeLfu = 2'd0;
  localparam logic [1:0] ModeLru = 2'd1;

  localparam logic [CfgIdxBits-1:0] RegMode    = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegMax     = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegTimeout = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegAge     = 2'd3;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [KeyBits-1:0]  key;
    logic [DataBits-1:0] data_in;
    logic [31:0]         entry_timeout;
    logic                refresh_on_hit;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic                expired;
    logic [DataBits-1:0] data_out;
  } rsp_t;

endpackage

>>> sv/lru_lfu_cache_policy_engine.sv
// Cache policy engine top level: one sequencer walks the 16 entries with one
// shared compare unit. Depends on llcpe_pkg.
//
//   channel  dir  handshake           payload
//   req      in   req_valid_i/ready_o  req_i (req_t)
//   rsp      out  rsp_valid_o/ready_i  rsp_o (rsp_t)
//   cfg      in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// Get and remove: accept, key scan, decide, finish, plus a rank pass for an
// LRU get of a present key or a remove that drops one. Set adds an insert, a
// free-slot search for a new key and in LRU a rank pass; eviction adds a victim
// search, and LFU eviction a rank sort. Clear: accept, finish. Tick: accept,
// finish, plus an age pass when counts are aged.
// An output register holds the finished word; the next word is taken while it
// waits, and the finish stalls until it drains. Reset clears valid bits,
// occupancy, tick and age counters and the output register.
module lru_lfu_cache_policy_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  output logic                                 req_ready_o,
  input  llcpe_pkg::req_t                      req_i,
  output logic                                 rsp_valid_o,
  input  logic                                 rsp_ready_i,
  output llcpe_pkg::rsp_t                      rsp_o,
  input  logic                                 cfg_we_i,
  input  logic [llcpe_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [llcpe_pkg::CfgBits-1:0]        cfg_data_i
);
  import llcpe_pkg::*;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StScan   = 4'd1;
  localparam logic [3:0] StDecide = 4'd2;
  localparam logic [3:0] StSort   = 4'd3;
  localparam logic [3:0] StSortWr = 4'd4;
  localparam logic [3:0] StVict   = 4'd5;
  localparam logic [3:0] StDrop   = 4'd6;
  localparam logic [3:0] StFree   = 4'd7;
  localparam logic [3:0] StIns    = 4'd8;
  localparam logic [3:0] StRank   = 4'd9;
  localparam logic [3:0] StAge    = 4'd10;
  localparam logic [3:0] StResp   = 4'd11;

  logic [3:0] state_q;

  logic [Capacity-1:0] vld_q;
  logic [KeyBits-1:0]  key_mem   [Capacity];
  logic [DataBits-1:0] data_mem  [Capacity];
  logic [CountBits-1:0] cnt_mem  [Capacity];
  logic [31:0]         snap_mem  [Capacity];
  logic [31:0]         exp_mem   [Capacity];
  logic [Capacity-1:0] refr_q;
  logic [IdxBits-1:0]  rank_mem  [Capacity];
  logic [IdxBits-1:0]  nrank_q   [Capacity];

  logic [OccBits-1:0] occ_q;
  logic [31:0] tick_q, age_q;
  logic [1:0]  mode_q;
  logic [OccBits-1:0] max_q;
  logic [31:0] dto_q, aint_q;

  req_t req_q;
  rsp_t rsp_q;
  rsp_t rsp_out_q;
  logic rsp_vld_q;

  logic [IdxBits-1:0] i_q, j_q;   // walk indexes
  logic [IdxBits:0]   cnt_i_q;    // sort inner count
  logic               found_q;
  logic [IdxBits-1:0] slot_q;
  logic [IdxBits-1:0] rref_q;     // rank reference for shift passes
  logic [1:0]         rop_q;      // rank pass kind
  localparam logic [1:0] RopDrop = 2'd0, RopFront = 2'd1, RopIns = 2'd2;

  assign req_ready_o = (state_q == StIdle);
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_out_q;

  wire last_i = (i_q == IdxBits'(Capacity-1));
  wire last_j = (j_q == IdxBits'(Capacity-1));
  wire [OccBits-1:0] eff_max =
      (max_q == '0) ? OccBits'(1) :
      (max_q > OccBits'(Capacity)) ? OccBits'(Capacity) : max_q;
  wire [31:0] lim_w = (exp_mem[slot_q] != '0) ? exp_mem[slot_q] : dto_q;
  wire [31:0] elapsed_w = tick_q - snap_mem[slot_q];
  wire [31:0] aint_eff = (aint_q == '0) ? 32'd1 : aint_q;
  wire [IdxBits-1:0] back_rank = IdxBits'(occ_q - OccBits'(1));
  // shared compare: j ranks ahead of i in the eviction sort
  wire beats = vld_q[j_q] && (j_q != i_q) &&
      ((cnt_mem[j_q] > cnt_mem[i_q]) ||
       ((cnt_mem[j_q] == cnt_mem[i_q]) && (rank_mem[j_q] < rank_mem[i_q])));
  // hand the finished word over once the output register is free
  wire rsp_load = (state_q == StResp) && (!rsp_vld_q || rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q <= '0;
      occ_q <= '0;
      tick_q <= '0;
      age_q <= '0;
      mode_q <= ModeLru;
      max_q <= OccBits'(16);
      dto_q <= '0;
      aint_q <= 32'd1000;
      rsp_vld_q <= 1'b0;
      rsp_out_q <= '0;
      i_q <= '0;
      j_q <= '0;
      cnt_i_q <= '0;
      found_q <= 1'b0;
      slot_q <= '0;
      rref_q <= '0;
      rop_q <= RopDrop;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMode:    mode_q <= cfg_data_i[1:0];
          RegMax:     max_q  <= cfg_data_i[OccBits-1:0];
          RegTimeout: dto_q  <= cfg_data_i;
          RegAge:     aint_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (rsp_load) rsp_vld_q <= 1'b1;
      else if (rsp_vld_q && rsp_ready_i) rsp_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (req_valid_i && req_ready_o) begin
            req_q <= req_i;
            rsp_q <= '0;
            i_q <= '0;
            found_q <= 1'b0;
            unique case (req_i.cmd)
              CmdGet, CmdSet, CmdRemove: state_q <= StScan;
              CmdClear: begin
                vld_q <= '0;
                occ_q <= '0;
                state_q <= StResp;
              end
              CmdTick: begin
                tick_q <= tick_q + 32'd1;
                if (mode_q == ModeLfu && age_q + 32'd1 >= aint_eff) begin
                  age_q <= '0;
                  state_q <= StAge;
                end else begin
                  if (mode_q == ModeLfu) age_q <= age_q + 32'd1;
                  state_q <= StResp;
                end
              end
              default: state_q <= StResp;
            endcase
          end
        end
        StScan: begin
          // first valid entry whose key matches
          if (!found_q && vld_q[i_q] && key_mem[i_q] == req_q.key) begin
            found_q <= 1'b1;
            slot_q <= i_q;
          end
          i_q <= i_q + IdxBits'(1);
          if (last_i) state_q <= StDecide;
        end
        StDecide: begin
          i_q <= '0;
          j_q <= '0;
          cnt_i_q <= '0;
          case (req_q.cmd)
            CmdGet: begin
              if (found_q && mode_q == ModeLfu) begin
                if (cnt_mem[slot_q] != '1) cnt_mem[slot_q] <= cnt_mem[slot_q] + CountBits'(1);
                rsp_q.hit <= 1'b1;
                rsp_q.data_out <= data_mem[slot_q];
                state_q <= StResp;
              end else if (found_q && mode_q == ModeLru) begin
                if (lim_w != '0 && lim_w <= elapsed_w) begin
                  rsp_q.expired <= 1'b1;
                end else begin
                  if (refr_q[slot_q]) snap_mem[slot_q] <= tick_q;
                  rsp_q.hit <= 1'b1;
                  rsp_q.data_out <= data_mem[slot_q];
                end
                rref_q <= rank_mem[slot_q];
                rop_q <= RopFront;
                state_q <= StRank;
              end else begin
                state_q <= StResp;
              end
            end
            CmdSet: begin
              if (mode_q == ModeLfu || mode_q == ModeLru) begin
                if (found_q) begin
                  state_q <= StIns;
                  if (mode_q == ModeLru) begin
                    rref_q <= rank_mem[slot_q];
                    rop_q <= RopFront;
                  end
                end else if (occ_q >= eff_max) begin
                  state_q <= (mode_q == ModeLfu) ? StSort : StVict;
                end else begin
                  state_q <= StFree;
                end
              end else begin
                state_q <= StResp;
              end
            end
            CmdRemove: begin
              if (found_q) begin
                rref_q <= rank_mem[slot_q];
                rop_q <= RopDrop;
                vld_q[slot_q] <= 1'b0;
                if (occ_q != '0) occ_q <= occ_q - OccBits'(1);
                state_q <= StRank;
              end else begin
                state_q <= StResp;
              end
            end
            default: state_q <= StResp;
          endcase
        end
        StSort: begin
          // count entries that sort ahead of entry i, one compare a cycle
          j_q <= j_q + IdxBits'(1);
          if (last_j) begin
            nrank_q[i_q] <= beats ? IdxBits'(cnt_i_q + (IdxBits+1)'(1))
                                  : IdxBits'(cnt_i_q);
            cnt_i_q <= '0;
            i_q <= i_q + IdxBits'(1);
            if (last_i) state_q <= StSortWr;
          end else if (beats) begin
            cnt_i_q <= cnt_i_q + (IdxBits+1)'(1);
          end
        end
        StSortWr: begin
          for (int k = 0; k < Capacity; k++) begin
            if (vld_q[k]) rank_mem[k] <= nrank_q[k];
          end
          i_q <= '0;
          state_q <= StVict;
        end
        StVict: begin
          // find back entry
          if (vld_q[i_q] && rank_mem[i_q] == back_rank) begin
            slot_q <= i_q;
            state_q <= StDrop;
          end else if (last_i) begin
            state_q <= StFree;
            i_q <= '0;
          end else begin
            i_q <= i_q + IdxBits'(1);
          end
        end
        StDrop: begin
          vld_q[slot_q] <= 1'b0;
          if (occ_q != '0) occ_q <= occ_q - OccBits'(1);
          // back entry: no other rank exceeds it
          i_q <= '0;
          state_q <= StFree;
        end
        StFree: begin
          if (!vld_q[i_q]) begin
            slot_q <= i_q;
            vld_q[i_q] <= 1'b1;
            key_mem[i_q] <= req_q.key;
            occ_q <= occ_q + OccBits'(1);
            if (mode_q == ModeLfu) begin
              rank_mem[i_q] <= IdxBits'(occ_q);
            end else begin
              rref_q <= '0;
              rop_q <= RopIns;
            end
            state_q <= StIns;
          end else if (last_i) begin
            state_q <= StResp;
          end else begin
            i_q <= i_q + IdxBits'(1);
          end
        end
        StIns: begin
          data_mem[slot_q] <= req_q.data_in;
          exp_mem[slot_q] <= req_q.entry_timeout;
          refr_q[slot_q] <= req_q.refresh_on_hit;
          if (mode_q == ModeLfu) begin
            cnt_mem[slot_q] <= CountBits'(1);
            snap_mem[slot_q] <= '0;
            state_q <= StResp;
          end else begin
            cnt_mem[slot_q] <= '0;
            snap_mem[slot_q] <= tick_q;
            state_q <= StRank;
          end
          i_q <= '0;
        end
        StRank: begin
          // one entry a cycle: shift ranks for drop, move-to-front or insert
          if (vld_q[i_q] && i_q != slot_q) begin
            case (rop_q)
              RopDrop:  if (rank_mem[i_q] > rref_q) rank_mem[i_q] <= rank_mem[i_q] - IdxBits'(1);
              RopFront: if (rank_mem[i_q] < rref_q) rank_mem[i_q] <= rank_mem[i_q] + IdxBits'(1);
              default:  rank_mem[i_q] <= rank_mem[i_q] + IdxBits'(1);
            endcase
          end
          i_q <= i_q + IdxBits'(1);
          if (last_i) begin
            if (rop_q != RopDrop) rank_mem[slot_q] <= '0;
            state_q <= StResp;
          end
        end
        StAge: begin
          if (vld_q[i_q]) begin
            cnt_mem[i_q] <= (cnt_mem[i_q][CountBits-1:1] == '0) ? CountBits'(1)
                            : {1'b0, cnt_mem[i_q][CountBits-1:1]};
          end
          i_q <= i_q + IdxBits'(1);
          if (last_i) state_q <= StResp;
        end
        StResp: begin
          // hold until the previous word has drained
          if (rsp_load) begin
            rsp_out_q <= rsp_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
